/* rtl/ico_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ico_pkg;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_UDP   = 2'd1,
    MODE_TCP   = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_e;

  localparam logic [15:0] WORD_ONES = 16'hFFFF;
  localparam logic [15:0] ODD_MASK  = 16'hFF00;

  // one item as held in the input register
  typedef struct packed {
    logic        first;
    logic        last;
    mode_e       mode;
    logic [15:0] seed;
    logic [15:0] word;
  } item_t;

  // end-around carry of a 17-bit sum
  function automatic logic [15:0] ones_fold17(input logic [16:0] s);
    logic [15:0] r;
    r = s[15:0] + {15'd0, s[16]};
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/ico_seed.sv */
`timescale 1ns / 1ps
`default_nettype none

module ico_seed
  import ico_pkg::*;
(
  input  mode_e       mode_i,
  input  logic [31:0] source_address_i,
  input  logic [31:0] destination_address_i,
  input  logic [7:0]  protocol_number_i,
  input  logic [15:0] segment_length_i,
  output logic [15:0] seed_o
);

  logic        use_ph;
  logic [18:0] total;
  logic [16:0] fold1;

  assign use_ph = (mode_i == MODE_UDP) || (mode_i == MODE_TCP);

  always_comb begin
    total = {3'd0, source_address_i[31:16]}
          + {3'd0, source_address_i[15:0]}
          + {3'd0, destination_address_i[31:16]}
          + {3'd0, destination_address_i[15:0]}
          + {11'd0, protocol_number_i}
          + {3'd0, segment_length_i};
    // two folds bring six words back to 16 bits
    fold1 = {1'b0, total[15:0]} + {14'd0, total[18:16]};
    seed_o = use_ph ? ones_fold17(fold1) : 16'd0;
  end

endmodule

`default_nettype wire

/* rtl/ico_accum.sv */
`timescale 1ns / 1ps
`default_nettype none

module ico_accum
  import ico_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        advance_i,
  input  item_t       item_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [15:0] checksum_value_o
);

  logic [15:0] running_sum_q, running_sum_d;
  mode_e       packet_mode_q, packet_mode_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] checksum_q, checksum_d;
  logic [15:0] base;

  always_comb begin
    base          = item_i.first ? item_i.seed : running_sum_q;
    running_sum_d = ones_fold17({1'b0, base} + {1'b0, item_i.word});
    packet_mode_d = item_i.first ? item_i.mode : packet_mode_q;
    checksum_d    = ~running_sum_d;
    // udp sends a zero checksum as all ones
    if ((packet_mode_d == MODE_UDP) && (checksum_d == 16'd0)) begin
      checksum_d = WORD_ONES;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance_i && item_i.last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sum_q <= 16'd0;
      packet_mode_q <= MODE_PLAIN;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance_i) begin
        running_sum_q <= running_sum_d;
        packet_mode_q <= packet_mode_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && item_i.last) begin
      checksum_q <= checksum_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign checksum_value_o = checksum_q;

endmodule

`default_nettype wire

/* rtl/internet_checksum_offload_core.sv */
// a checksum reaches the output register via the input register and the result register
// throughput: one item per cycle unless a last item waits for the result register to be
// taken; the running sum takes one 16-bit end-around add per item between the input register and the result register
// pseudo-header seed is summed on the way into the input register
// reset (rst_ni low, async) clears both valid flags, the running sum and mode
`timescale 1ns / 1ps
`default_nettype none

module internet_checksum_offload_core
  import ico_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] data_word_i,
  input  logic        first_word_i,
  input  logic        last_word_i,
  input  logic        odd_byte_i,
  input  logic [31:0] source_address_i,
  input  logic [31:0] destination_address_i,
  input  logic [7:0]  protocol_number_i,
  input  logic [15:0] segment_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] checksum_value_o
);

  logic        s1_valid_q, s1_valid_d;
  item_t       s1_item_q, s1_item_d;
  logic [15:0] seed;
  logic        accept;
  logic        advance;

  ico_seed u_seed (
    .mode_i                (mode_e'(mode_i)),
    .source_address_i      (source_address_i),
    .destination_address_i (destination_address_i),
    .protocol_number_i     (protocol_number_i),
    .segment_length_i      (segment_length_i),
    .seed_o                (seed)
  );

  // a last item needs room in the result register, others move on freely
  assign advance    = s1_valid_q && (!s1_item_q.last || !out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    s1_item_d.first = first_word_i;
    s1_item_d.last  = last_word_i;
    s1_item_d.mode  = mode_e'(mode_i);
    s1_item_d.seed  = seed;
    s1_item_d.word  = (last_word_i && odd_byte_i) ? (data_word_i & ODD_MASK) : data_word_i;
    s1_valid_d      = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= s1_item_d;
    end
  end

  ico_accum u_accum (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .item_i           (s1_item_q),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .checksum_value_o (checksum_value_o)
  );

  a_last_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_item_q.last |=> out_valid_o)
    else $error("last item did not produce a result");

  a_no_spurious_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !s1_item_q.last && !(out_valid_o && !out_ready_i) |=> !out_valid_o)
    else $error("result appeared without a last item");

  a_stall_reason : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s1_item_q.last && out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked last item");

endmodule

`default_nettype wire

/* verif/internet_checksum_offload_core_tb.sv */
`timescale 1ns / 1ps

module internet_checksum_offload_core_tb;
  import ico_pkg::*;

  localparam int unsigned RANDOM_WORDS = 2000;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_CYCLES  = 8;

  typedef struct {
    mode_e       mode;
    logic [15:0] word;
    logic        first;
    logic        last;
    logic        odd;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [15:0] seg_len;
  } word_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = 2'd0;
  logic [15:0] data_word_i = 16'd0;
  logic        first_word_i = 1'b0;
  logic        last_word_i = 1'b0;
  logic        odd_byte_i = 1'b0;
  logic [31:0] source_address_i = 32'd0;
  logic [31:0] destination_address_i = 32'd0;
  logic [7:0]  protocol_number_i = 8'd0;
  logic [15:0] segment_length_i = 16'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] checksum_value_o;

  logic        hold_out = 1'b0;

  word_item_t  word_q[$];
  logic [15:0] checksum_q[$];
  word_item_t  cur_item;
  int unsigned total_words = 0;
  int unsigned words_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned err_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;

  // predictor state
  logic [15:0] sum_acc = 16'd0;
  mode_e       latched_mode = MODE_PLAIN;

  internet_checksum_offload_core dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .mode_i                (mode_i),
    .data_word_i           (data_word_i),
    .first_word_i          (first_word_i),
    .last_word_i           (last_word_i),
    .odd_byte_i            (odd_byte_i),
    .source_address_i      (source_address_i),
    .destination_address_i (destination_address_i),
    .protocol_number_i     (protocol_number_i),
    .segment_length_i      (segment_length_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .checksum_value_o      (checksum_value_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [15:0] add_ones(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic logic [15:0] pseudo_seed(input logic [31:0] src, input logic [31:0] dst,
                                              input logic [7:0] proto,
                                              input logic [15:0] seg_len);
    logic [15:0] s;
    s = add_ones(16'd0, src[31:16]);
    s = add_ones(s, src[15:0]);
    s = add_ones(s, dst[31:16]);
    s = add_ones(s, dst[15:0]);
    s = add_ones(s, {8'd0, proto});
    s = add_ones(s, seg_len);
    return s;
  endfunction

  task automatic fold_checksum_word(input word_item_t it);
    logic [15:0] acc;
    logic [15:0] w;
    logic [15:0] cs;
    if (it.first) begin
      latched_mode = it.mode;
      acc = 16'd0;
      if (it.mode == MODE_UDP || it.mode == MODE_TCP) begin
        acc = pseudo_seed(it.src, it.dst, it.proto, it.seg_len);
      end
    end else begin
      acc = sum_acc;
    end
    w = it.word;
    if (it.last && it.odd) begin
      w = w & ODD_MASK;
    end
    acc = add_ones(acc, w);
    sum_acc = acc;
    if (it.last) begin
      cs = ~acc;
      // udp sends a zero checksum as all ones
      if (latched_mode == MODE_UDP && cs == 16'd0) begin
        cs = WORD_ONES;
      end
      checksum_q.push_back(cs);
    end
  endtask

  task automatic push_word(input mode_e mode, input logic [15:0] word, input logic first,
                           input logic last, input logic odd, input logic [31:0] src,
                           input logic [31:0] dst, input logic [7:0] proto,
                           input logic [15:0] seg_len);
    word_item_t it;
    it.mode = mode;
    it.word = word;
    it.first = first;
    it.last = last;
    it.odd = odd;
    it.src = src;
    it.dst = dst;
    it.proto = proto;
    it.seg_len = seg_len;
    word_q.push_back(it);
    total_words++;
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic gen_packet();
    mode_e       mode;
    int unsigned r;
    int unsigned n;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [15:0] seg_len;
    logic [15:0] word;
    logic        odd;
    logic        last;
    r = $urandom_range(0, 15);
    mode = (r < 5) ? MODE_PLAIN : (r < 10) ? MODE_UDP : (r < 15) ? MODE_TCP : MODE_RSVD;
    src = $urandom;
    dst = $urandom;
    proto = 8'($urandom_range(0, 255));
    seg_len = 16'($urandom_range(0, 65535));
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    for (int unsigned i = 0; i < n; i++) begin
      last = (i == n - 1);
      odd = last ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0);
      word = 16'($urandom_range(0, 65535));
      // one-word packet steered onto a zero checksum
      if (n == 1 && $urandom_range(0, 3) == 0) begin
        odd = 1'b0;
        word = (mode == MODE_UDP || mode == MODE_TCP) ?
               ~pseudo_seed(src, dst, proto, seg_len) : 16'hFFFF;
      end
      if (i == 0) begin
        push_word(mode, word, 1'b1, last, odd, src, dst, proto, seg_len);
      end else begin
        // pseudo-header fields are garbage past the first word
        push_word(mode_e'($urandom_range(0, 3)), word, 1'b0, last, odd, $urandom, $urandom,
                  8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      end
    end
  endtask

  task automatic build_stimulus();
    logic [15:0] seed;
    // plain one-word packets at both extremes
    push_word(MODE_PLAIN, 16'h0000, 1'b1, 1'b1, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF,
              16'hFFFF);
    push_word(MODE_PLAIN, 16'hFFFF, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0, 8'd0, 16'd0);
    // udp summing to zero gets mapped
    seed = pseudo_seed(32'hFFFFFFFF, 32'h00000000, 8'hFF, 16'hFFFF);
    push_word(MODE_UDP, ~seed, 1'b1, 1'b1, 1'b0, 32'hFFFFFFFF, 32'h00000000, 8'hFF, 16'hFFFF);
    // same for tcp, no mapping
    seed = pseudo_seed(32'h00000000, 32'hFFFFFFFF, 8'h06, 16'h0014);
    push_word(MODE_TCP, ~seed, 1'b1, 1'b1, 1'b0, 32'h00000000, 32'hFFFFFFFF, 8'h06, 16'h0014);
    // reserved mode ignores the pseudo-header
    push_word(MODE_RSVD, 16'hFFFF, 1'b1, 1'b1, 1'b0, 32'hDEADBEEF, 32'hC0A80001, 8'h11,
              16'h1234);
    // udp zero-seed, zero data
    push_word(MODE_UDP, 16'h0000, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0, 8'd0, 16'd0);
    // udp, odd byte on a middle word is ignored, odd last byte masked
    push_word(MODE_UDP, 16'h1234, 1'b1, 1'b0, 1'b0, 32'hC0A80001, 32'hC0A800C7, 8'h11,
              16'h000B);
    push_word(MODE_UDP, 16'hABCD, 1'b0, 1'b0, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF,
              16'hFFFF);
    push_word(MODE_TCP, 16'h56FF, 1'b0, 1'b1, 1'b1, 32'd0, 32'd0, 8'd0, 16'd0);
    // continuation after a last word keeps sum and udp mode
    push_word(MODE_PLAIN, 16'h00FF, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0, 8'd0, 16'd0);
    push_word(MODE_TCP, 16'h8001, 1'b0, 1'b0, 1'b0, 32'hFFFFFFFF, 32'd0, 8'hFF, 16'd0);
    push_word(MODE_PLAIN, 16'h7FFE, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0, 8'd0, 16'd0);
    // tcp with extremes and carries
    push_word(MODE_TCP, 16'hFFFF, 1'b1, 1'b0, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF,
              16'hFFFF);
    push_word(MODE_PLAIN, 16'hFFFF, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 8'd0, 16'd0);
    push_word(MODE_PLAIN, 16'h0001, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 8'd0, 16'd0);
    push_word(MODE_PLAIN, 16'hFFFF, 1'b0, 1'b1, 1'b1, 32'd0, 32'd0, 8'd0, 16'd0);
    // plain multiword, odd last
    push_word(MODE_PLAIN, 16'h4500, 1'b1, 1'b0, 1'b0, 32'h01020304, 32'h05060708, 8'h01,
              16'h0040);
    push_word(MODE_PLAIN, 16'h0073, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 8'd0, 16'd0);
    push_word(MODE_PLAIN, 16'hAB01, 1'b0, 1'b1, 1'b1, 32'd0, 32'd0, 8'd0, 16'd0);

    while (total_words < 19 + RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        push_word(mode_e'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), $urandom, $urandom, 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 65535)));
      end else begin
        gen_packet();
      end
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        fold_checksum_word(cur_item);
        words_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (word_q.size() > 0) begin
          cur_item = word_q.pop_front();
          mode_i <= cur_item.mode;
          data_word_i <= cur_item.word;
          first_word_i <= cur_item.first;
          last_word_i <= cur_item.last;
          odd_byte_i <= cur_item.odd;
          source_address_i <= cur_item.src;
          destination_address_i <= cur_item.dst;
          protocol_number_i <= cur_item.proto;
          segment_length_i <= cur_item.seg_len;
          in_valid_i <= 1'b1;
          // back-to-back stretches of 64 accepted items in every 256
          gap_left = ((words_accepted / 64) % 4 == 3) ? 0 : $urandom_range(0, 5);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] exp_cs;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (checksum_q.size() == 0) begin
          report_mismatch($sformatf("checksum 0x%h with no packet pending", checksum_value_o));
        end else begin
          exp_cs = checksum_q.pop_front();
          if (checksum_value_o !== exp_cs) begin
            report_mismatch($sformatf("checksum_value got 0x%h exp 0x%h",
                                      checksum_value_o, exp_cs));
          end
        end
        results_seen++;
        stall_left = ((results_seen / 40) % 3 == 2) ? 0 : $urandom_range(0, 5);
      end
      if (hold_out) begin
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    while (results_seen < 60) @(posedge clk_i);
    hold_out <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_out <= 1'b0;
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("** internet_checksum_offload_core: FAILED **");
    $finish;
  end

  initial begin
    build_stimulus();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(words_accepted == total_words && checksum_q.size() == 0)) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("** internet_checksum_offload_core: PASSED **");
    end else begin
      $display("** internet_checksum_offload_core: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ico_pkg.sv
rtl/ico_seed.sv
rtl/ico_accum.sv
rtl/internet_checksum_offload_core.sv
verif/internet_checksum_offload_core_tb.sv
